// File: design/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros: assertion helpers for the script token scanner checkers
// Clocked assertion wrappers, with and without the reset mask.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is asserted.
`define SCR_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("scanner assertion failed");

// Clocked assertion that is also checked during reset.
`define SCR_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("scanner assertion failed");

`endif

// File: design/scr_pkg.sv
// ---------------------------------------------------------------------------
// scr_pkg: shared types and helpers for the script token scanner
// Result record, scan state, keyword table and per-byte step functions.
// ---------------------------------------------------------------------------
package scr_pkg;

  localparam int LENGTH_BITS   = 16;
  localparam int POSITION_BITS = 32;
  localparam int MAX_RESULTS   = 3;

  typedef logic [POSITION_BITS-1:0] pos_t;
  typedef logic [LENGTH_BITS-1:0]   len_t;
  typedef logic [5:0]               kind_t;

  localparam len_t LEN_MAX = {LENGTH_BITS{1'b1}};

  localparam kind_t K_BEGIN    = 6'd0;
  localparam kind_t K_NONE     = 6'd0;  // only as "no single-char kind"
  localparam kind_t K_IDENT    = 6'd26;
  localparam kind_t K_STRING   = 6'd27;
  localparam kind_t K_NUMBER   = 6'd28;
  localparam kind_t K_KEYWORD0 = 6'd29;
  localparam kind_t K_MAX      = 6'd44;

  typedef enum logic [3:0] {
    M_IDLE, M_IDENT, M_NUM_INT, M_NUM_FRAC, M_STRING, M_OP,
    M_LINE_COMMENT, M_BLOCK_COMMENT
  } mode_t;

  typedef struct packed {
    kind_t kind;
    pos_t  start_offset;
    len_t  length;
    pos_t  line;
    pos_t  column;
    logic  last_result;
  } result_t;

  typedef struct packed {
    mode_t           mode;
    logic            at_start;
    pos_t            bo;
    pos_t            ts;
    len_t            tl;
    pos_t            lc;
    pos_t            cc;
    logic [7:0]      po;
    logic [5:0][7:0] kw;
    logic            ss;
  } scan_t;

  typedef struct packed {
    result_t [MAX_RESULTS-1:0] res;
    logic [1:0]                cnt;
  } push_t;

  typedef struct packed {
    scan_t s;
    push_t p;
  } step_t;

  localparam scan_t SCAN_RESET = '{
    mode: M_IDLE, at_start: 1'b1, bo: '0, ts: '0, tl: '0,
    lc: pos_t'(1), cc: pos_t'(1), po: '0, kw: '0, ss: 1'b0
  };

  localparam logic [47:0] KW_TEXT [16] = '{
    48'("and"), 48'("or"), 48'("if"), 48'("else"), 48'("class"), 48'("false"),
    48'("true"), 48'("func"), 48'("null"), 48'("print"), 48'("return"),
    48'("super"), 48'("this"), 48'("var"), 48'("for"), 48'("while")
  };
  localparam logic [2:0] KW_LEN [16] = '{
    3'd3, 3'd2, 3'd2, 3'd4, 3'd5, 3'd5, 3'd4, 3'd4,
    3'd4, 3'd5, 3'd6, 3'd5, 3'd4, 3'd3, 3'd3, 3'd5
  };

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic takes_equal(logic [7:0] c);
    return c == "-" || c == "+" || c == "/" || c == "*" ||
           c == "!" || c == "=" || c == ">" || c == "<";
  endfunction

  // Zero means the byte is not a punctuator.
  function automatic kind_t single_kind(logic [7:0] c);
    kind_t k;
    case (c)
      "(":     k = 6'd1;
      ")":     k = 6'd2;
      "{":     k = 6'd3;
      "}":     k = 6'd4;
      ",":     k = 6'd5;
      ".":     k = 6'd6;
      "-":     k = 6'd7;
      "+":     k = 6'd9;
      ";":     k = 6'd11;
      ":":     k = 6'd12;
      "?":     k = 6'd13;
      "/":     k = 6'd14;
      "*":     k = 6'd16;
      "!":     k = 6'd18;
      "=":     k = 6'd20;
      ">":     k = 6'd22;
      "<":     k = 6'd24;
      default: k = K_NONE;
    endcase
    return k;
  endfunction

  function automatic kind_t ident_kind(scan_t s);
    logic [47:0] v;
    kind_t       k;
    v = '0;
    k = K_IDENT;
    for (int j = 0; j < 6; j++) begin
      if (len_t'(j) < s.tl) v = {v[39:0], s.kw[j]};
    end
    if (s.tl <= len_t'(6)) begin
      for (int i = 0; i < 16; i++) begin
        if (s.tl == len_t'(KW_LEN[i]) && v == KW_TEXT[i]) k = K_KEYWORD0 + kind_t'(i);
      end
    end
    return k;
  endfunction

  function automatic step_t emit(step_t w, kind_t k, pos_t start, len_t len);
    result_t r;
    r.kind         = k;
    r.start_offset = start;
    r.length       = len;
    r.line         = w.s.lc;
    r.column       = w.s.cc;
    r.last_result  = 1'b0;
    if (w.p.cnt < 2'(MAX_RESULTS)) begin
      w.p.res[w.p.cnt] = r;
      w.p.cnt          = w.p.cnt + 2'd1;
    end
    return w;
  endfunction

  function automatic step_t consume(step_t w, logic [7:0] c);
    if (c == 8'h0A) begin
      w.s.lc = w.s.lc + pos_t'(1);
      w.s.cc = '0;
    end
    if (w.s.tl != LEN_MAX) w.s.tl = w.s.tl + len_t'(1);
    w.s.bo = w.s.bo + pos_t'(1);
    return w;
  endfunction

  function automatic step_t finish(step_t w, logic v, kind_t k);
    if (v) w = emit(w, k, w.s.ts, w.s.tl);
    w.s.cc   = w.s.cc + (w.s.bo - w.s.ts);
    w.s.mode = M_IDLE;
    return w;
  endfunction

  function automatic step_t start_token(step_t w, logic [7:0] c);
    kind_t sk;
    w.s.ts = w.s.bo;
    w.s.tl = '0;
    w      = consume(w, c);
    sk     = single_kind(c);
    if (is_alpha(c)) begin
      w.s.kw[0] = c;
      w.s.mode  = M_IDENT;
    end else if (is_digit(c)) begin
      w.s.mode = M_NUM_INT;
    end else if (c == "\"") begin
      w.s.mode = M_STRING;
    end else if (takes_equal(c)) begin
      w.s.po   = c;
      w.s.mode = M_OP;
    end else begin
      w = finish(w, sk != K_NONE, sk);
    end
    return w;
  endfunction

endpackage

// File: design/scr_lexer_core.sv
// ---------------------------------------------------------------------------
// scr_lexer_core: scan state register and per-byte step logic
// Produces up to three result records for each accepted byte.
// ---------------------------------------------------------------------------
module scr_lexer_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           accept,
  input  logic [7:0]     ch,
  input  logic           last_byte,
  output scr_pkg::push_t push
);

  scr_pkg::scan_t state_r, state_nxt;

  always_comb begin
    scr_pkg::step_t w;
    logic           pre, fin, fin_v, strt;
    scr_pkg::kind_t fk, sk;
    w       = '0;
    w.s     = state_r;
    pre     = 1'b0;
    fin     = 1'b0;
    fin_v   = 1'b0;
    strt    = 1'b0;
    fk      = scr_pkg::K_NONE;
    sk      = scr_pkg::single_kind(state_r.po);
    if (w.s.at_start) begin
      w = scr_pkg::emit(w, scr_pkg::K_BEGIN, w.s.bo, '0);
      w.s.at_start = 1'b0;
    end
    unique case (w.s.mode)
      scr_pkg::M_IDENT: begin
        if (scr_pkg::is_alpha(ch) || scr_pkg::is_digit(ch)) begin
          if (w.s.tl < scr_pkg::len_t'(6)) w.s.kw[w.s.tl[2:0]] = ch;
          pre = 1'b1;
        end else begin
          fin = 1'b1; fin_v = 1'b1; fk = scr_pkg::ident_kind(w.s); strt = 1'b1;
        end
      end
      scr_pkg::M_NUM_INT: begin
        if (scr_pkg::is_digit(ch)) begin
          pre = 1'b1;
        end else if (ch == ".") begin
          pre = 1'b1; w.s.mode = scr_pkg::M_NUM_FRAC;
        end else begin
          fin = 1'b1; fin_v = 1'b1; fk = scr_pkg::K_NUMBER; strt = 1'b1;
        end
      end
      scr_pkg::M_NUM_FRAC: begin
        if (scr_pkg::is_digit(ch)) begin
          pre = 1'b1;
        end else begin
          fin = 1'b1; fin_v = 1'b1; fk = scr_pkg::K_NUMBER; strt = 1'b1;
        end
      end
      scr_pkg::M_STRING: begin
        pre = 1'b1;
        if (ch == "\"") begin
          fin = 1'b1; fin_v = 1'b1; fk = scr_pkg::K_STRING;
        end
      end
      scr_pkg::M_OP: begin
        if (ch == "=") begin
          pre = 1'b1; fin = 1'b1; fin_v = 1'b1; fk = sk + 6'd1;
        end else if (w.s.po == "/" && ch == "/") begin
          pre = 1'b1; w.s.mode = scr_pkg::M_LINE_COMMENT;
        end else if (w.s.po == "/" && ch == "*") begin
          pre = 1'b1; w.s.ss = 1'b0; w.s.mode = scr_pkg::M_BLOCK_COMMENT;
        end else begin
          fin = 1'b1; fin_v = sk != scr_pkg::K_NONE; fk = sk; strt = 1'b1;
        end
      end
      scr_pkg::M_LINE_COMMENT: begin
        if (ch == 8'h0A) begin
          fin = 1'b1; strt = 1'b1;
        end else begin
          pre = 1'b1;
        end
      end
      scr_pkg::M_BLOCK_COMMENT: begin
        pre = 1'b1;
        if (w.s.ss && ch == "/") fin = 1'b1;
        else w.s.ss = (ch == "*");
      end
      default: strt = 1'b1;
    endcase
    if (pre)  w = scr_pkg::consume(w, ch);
    if (fin)  w = scr_pkg::finish(w, fin_v, fk);
    if (strt) w = scr_pkg::start_token(w, ch);
    if (last_byte) begin
      sk = scr_pkg::single_kind(w.s.po);
      unique case (w.s.mode)
        scr_pkg::M_IDENT:    w = scr_pkg::finish(w, 1'b1, scr_pkg::ident_kind(w.s));
        scr_pkg::M_NUM_INT,
        scr_pkg::M_NUM_FRAC: w = scr_pkg::finish(w, 1'b1, scr_pkg::K_NUMBER);
        scr_pkg::M_OP:       w = scr_pkg::finish(w, sk != scr_pkg::K_NONE, sk);
        default:             ;
      endcase
      w.s = scr_pkg::SCAN_RESET;
    end
    if (w.p.cnt != 2'd0) w.p.res[w.p.cnt - 2'd1].last_result = 1'b1;
    state_nxt = w.s;
    push      = w.p;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= scr_pkg::SCAN_RESET;
    end else if (accept) begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: design/scr_result_fifo.sv
// ---------------------------------------------------------------------------
// scr_result_fifo: four-entry result queue
// Takes up to three records per cycle, hands out one per cycle while out_ready is high.
// ---------------------------------------------------------------------------
module scr_result_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_en,
  input  scr_pkg::push_t   push,
  output logic             space_ok,
  output logic             out_valid,
  input  logic             out_ready,
  output scr_pkg::result_t out_data
);

  scr_pkg::result_t mem [4];
  logic [1:0] wr_ptr_r, rd_ptr_r;
  logic [2:0] count_r, count_nxt;
  logic [1:0] n_push;
  logic       pop;

  assign n_push    = push_en ? push.cnt : 2'd0;
  assign out_valid = count_r != 3'd0;
  assign pop       = out_valid & out_ready;
  assign space_ok  = count_r <= 3'd1;
  assign out_data  = mem[rd_ptr_r];
  assign count_nxt = count_r + {1'b0, n_push} - {2'b00, pop};

  always_ff @(posedge clk) begin
    for (int k = 0; k < scr_pkg::MAX_RESULTS; k++) begin
      if (2'(k) < n_push) mem[wr_ptr_r + 2'(k)] <= push.res[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + n_push;
      rd_ptr_r <= rd_ptr_r + {1'b0, pop};
      count_r  <= count_nxt;
    end
  end

endmodule

// File: design/script_token_scanner_unit.sv
// A token's record is written into the result queue when the byte that ends it is accepted.
// Throughput: one byte per cycle while the four-entry result queue holds at most one
//   record; a byte is taken only when at least three queue slots are free.
// Reset (rst_n low, synchronous): scan state back to text start, line 1, column 1,
//   result queue emptied.
// ---------------------------------------------------------------------------
// script_token_scanner_unit: streaming lexer top level
// Byte stream in, token records (kind, span, line, column) out.
// ---------------------------------------------------------------------------
module script_token_scanner_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [7:0]                        in_ch,
  input  logic                              in_last_byte,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [5:0]                        out_kind,
  output logic [scr_pkg::POSITION_BITS-1:0] out_start_offset,
  output logic [scr_pkg::LENGTH_BITS-1:0]   out_length,
  output logic [scr_pkg::POSITION_BITS-1:0] out_line,
  output logic [scr_pkg::POSITION_BITS-1:0] out_column,
  output logic                              out_last_result
);

  // request accepted when valid and ready meet
  logic             accept;
  scr_pkg::push_t   push;
  scr_pkg::result_t head;

  assign accept = in_valid & in_ready;

  // scan state plus the per-byte step: up to three records per request
  scr_lexer_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .ch        (in_ch),
    .last_byte (in_last_byte),
    .push      (push)
  );

  // queue decouples record bursts (up to three) from the output side
  scr_result_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_en   (accept),
    .push      (push),
    .space_ok  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (head)
  );

  assign out_kind         = head.kind;
  assign out_start_offset = head.start_offset;
  assign out_length       = head.length;
  assign out_line         = head.line;
  assign out_column       = head.column;
  assign out_last_result  = head.last_result;

endmodule

// File: design/scr_checker.sv
// ---------------------------------------------------------------------------
// scr_checker: port-level checks for the scanner
// Bound to the top level; watches the result channel.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module scr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [5:0]  out_kind,
  input logic [scr_pkg::LENGTH_BITS-1:0] out_length
);

  `SCR_ASSERT(a_hold_valid, clk, rst_n, out_valid && !out_ready |=> out_valid)
  `SCR_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid)
  `SCR_ASSERT(a_begin_len, clk, rst_n, out_valid && out_kind == scr_pkg::K_BEGIN |-> out_length == '0)
  `SCR_ASSERT(a_kind_range, clk, rst_n, out_valid |-> out_kind <= scr_pkg::K_MAX)

endmodule

bind script_token_scanner_unit scr_checker u_scr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_kind   (out_kind),
  .out_length (out_length)
);
